### design/rlm_pkg.sv
package rlm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_COUNT  = 3'd0,
        CFG_HOLD_TIME      = 3'd1,
        CFG_STALE_TIMEOUT  = 3'd2,
        CFG_NORMAL_DECAY   = 3'd3,
        CFG_STALE_DECAY    = 3'd4,
        CFG_AVERAGE_SHIFT  = 3'd5
    } t_cfg_idx;

    // register reset values
    localparam logic [6:0]  RST_SEGMENT_COUNT = 7'd38;
    localparam logic [15:0] RST_HOLD_TIME     = 16'd800;
    localparam logic [15:0] RST_STALE_TIMEOUT = 16'd5000;
    localparam logic [15:0] RST_NORMAL_DECAY  = 16'd26;
    localparam logic [15:0] RST_STALE_DECAY   = 16'd98;
    localparam logic [2:0]  RST_AVERAGE_SHIFT = 3'd2;

    // level and fraction constants
    localparam logic signed [15:0] LEVEL_FLOOR_Q88 = -16'sd25600;
    localparam logic signed [17:0] FRAC_OFFSET     = 18'sd25600;
    localparam logic signed [17:0] FRAC_SPAN       = 18'sd15360;
    localparam logic [16:0]        FRAC_ONE        = 17'd65536;
    localparam logic [20:0]        RECIP_15        = 21'd1118482;  // ceil(2^24 / 15)
    localparam int                 RECIP_SHIFT     = 24;

    // timing constants
    localparam int          GAP_LIMIT   = 1000;
    localparam logic [9:0]  GAP_DEFAULT = 10'd50;

    // display constants
    localparam logic [15:0]       SEG_ROUND      = 16'd655;
    localparam logic [16:0]       PEAK_VIS_MIN   = 17'd1310;
    localparam logic [15:0]       HALF_FRAC      = 16'd32768;
    localparam logic [6:0]        PCT_SCALE      = 7'd100;
    localparam logic [5:0]        DBM_SPAN       = 6'd60;
    localparam logic signed [7:0] DBM_FLOOR      = 8'sd100;
    localparam logic signed [8:0] LEVEL_ROUND    = 9'sd128;

    typedef struct packed {
        logic [6:0]  seg_n;          // clamped segment count
        logic [15:0] hold_time;
        logic [15:0] stale_timeout;
        logic [15:0] normal_decay;
        logic [15:0] stale_decay;
        logic [2:0]  avg_shift;
    } t_cfg;

    typedef struct packed {
        logic [16:0]        smooth;
        logic [16:0]        peak;
        logic               stale;
        logic signed [15:0] avg;
    } t_level;

    typedef struct packed {
        logic [6:0]        lit_segments;
        logic [5:0]        peak_segment;
        logic              peak_visible;
        logic              is_stale;
        logic [6:0]        range_percent;
        logic signed [7:0] level_dbm;
        logic signed [7:0] peak_dbm;
        logic              redraw;
    } t_result;

    // q8.8 dBm to q0.16 fraction of -100..-40 dBm, clamped; off*64/15 by reciprocal
    function automatic logic [16:0] level_to_frac(input logic signed [15:0] q88);
        logic signed [17:0] off;
        logic [19:0]        scaled;
        logic [40:0]        prod;
        logic [16:0]        frac;
        off    = 18'(q88) + FRAC_OFFSET;
        scaled = {off[13:0], 6'b0};
        prod   = 41'(scaled) * 41'(RECIP_15);
        if (off <= 18'sd0) begin
            frac = '0;
        end else if (off >= FRAC_SPAN) begin
            frac = FRAC_ONE;
        end else begin
            frac = prod[RECIP_SHIFT +: 17];
        end
        return frac;
    endfunction

endpackage

### design/rlm_frame_if.sv
interface rlm_frame_if #(
    parameter int TIME_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] frame_time_ms;
    logic                  sample_present;
    logic signed [7:0]     sample_dbm;
    logic [TIME_WIDTH-1:0] sample_time_ms;

    modport source (
        output valid, frame_time_ms, sample_present, sample_dbm, sample_time_ms,
        input  ready
    );
    modport sink (
        input  valid, frame_time_ms, sample_present, sample_dbm, sample_time_ms,
        output ready
    );
endinterface

### design/rlm_result_if.sv
interface rlm_result_if;
    logic              valid;
    logic              ready;
    logic [6:0]        lit_segments;
    logic [5:0]        peak_segment;
    logic              peak_visible;
    logic              is_stale;
    logic [6:0]        range_percent;
    logic signed [7:0] level_dbm;
    logic signed [7:0] peak_dbm;
    logic              redraw;

    modport source (
        output valid, lit_segments, peak_segment, peak_visible, is_stale,
               range_percent, level_dbm, peak_dbm, redraw,
        input  ready
    );
    modport sink (
        input  valid, lit_segments, peak_segment, peak_visible, is_stale,
               range_percent, level_dbm, peak_dbm, redraw,
        output ready
    );
endinterface

### design/rssi_level_peak_hold_meter.sv
// channel     direction  carries
// i_frame     in         frame time, sample present flag, sample dBm, sample stamp
// o_result    out        lit/peak segments, peak visible, stale, percent, dBm levels, redraw
// i_cfg_*     in         register writes, index 0..5, no read-back
//
// one frame per cycle sustained while results are taken; an accepted beat reaches the
// result beat through the input register, level register and result register
// tracker state is updated as a frame leaves the input register, so a frame sees
// the state left by the frame just before it
// synchronous active-low reset clears the stage valid flags and restores the
// registers, tracker and display defaults; payload registers are not reset
// a stalled result holds; empty stages behind it still fill, ready drops only
// when all three stages are full and the result is not taken
module rssi_level_peak_hold_meter #(
    parameter int TIME_WIDTH   = 32,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rlm_frame_if.sink                       i_frame,
    rlm_result_if.source                    o_result
);

    // pipeline occupancy
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;

    // input register, payload only
    logic [TIME_WIDTH-1:0] r_in_now;
    logic                  r_in_present;
    logic signed [7:0]     r_in_dbm;
    logic [TIME_WIDTH-1:0] r_in_stamp;

    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s1_go;
    logic s2_go;
    logic in_fire;

    rlm_pkg::t_cfg    cfg;
    rlm_pkg::t_level  level;
    rlm_pkg::t_result result;

    // backward ready chain: a stage may load when it is empty or moving on
    assign out_free = !r_out_valid || o_result.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign s1_go    = r_s1_valid && s2_free;
    assign s2_go    = r_s2_valid && out_free;
    assign in_fire  = i_frame.valid && s1_free;

    assign i_frame.ready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_frame.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_now     <= i_frame.frame_time_ms;
            r_in_present <= i_frame.sample_present;
            r_in_dbm     <= i_frame.sample_dbm;
            r_in_stamp   <= i_frame.sample_time_ms;
        end
    end

    rlm_cfg #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // averaging, staleness, peak capture and decay
    rlm_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (s1_go),
        .i_cfg     (cfg),
        .i_now     (r_in_now),
        .i_present (r_in_present),
        .i_dbm     (r_in_dbm),
        .i_stamp   (r_in_stamp),
        .o_level   (level)
    );

    // segment mapping, rounding and redraw tracking
    rlm_display u_display (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s2_go),
        .i_seg_n  (cfg.seg_n),
        .i_level  (level),
        .o_result (result)
    );

    assign o_result.valid         = r_out_valid;
    assign o_result.lit_segments  = result.lit_segments;
    assign o_result.peak_segment  = result.peak_segment;
    assign o_result.peak_visible  = result.peak_visible;
    assign o_result.is_stale      = result.is_stale;
    assign o_result.range_percent = result.range_percent;
    assign o_result.level_dbm     = result.level_dbm;
    assign o_result.peak_dbm      = result.peak_dbm;
    assign o_result.redraw        = result.redraw;

    // held peak never sits below the smoothed level
    a_peak_above_smooth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (level.peak >= level.smooth))
        else $error("peak below smoothed level");

    // a stale result shows an empty bar and no peak marker
    a_stale_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && result.is_stale) |->
            (result.lit_segments == 7'd0 && !result.peak_visible))
        else $error("stale result not blanked");

    // peak marker stays on the bar
    a_peak_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (7'(result.peak_segment) < cfg.seg_n))
        else $error("peak segment beyond bar");

    // an accepted beat always lands in the input register
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat lost");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (result.range_percent <= rlm_pkg::PCT_SCALE))
        else $error("range percent above full scale");

endmodule

### design/rlm_cfg.sv
module rlm_cfg #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rlm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rlm_pkg::t_cfg                    o_cfg
);

    localparam logic [6:0] SEG_CAP = 7'((MAX_SEGMENTS < 127) ? MAX_SEGMENTS : 127);

    logic [6:0]  r_seg_count;
    logic [15:0] r_hold_time;
    logic [15:0] r_stale_timeout;
    logic [15:0] r_normal_decay;
    logic [15:0] r_stale_decay;
    logic [2:0]  r_avg_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count     <= rlm_pkg::RST_SEGMENT_COUNT;
            r_hold_time     <= rlm_pkg::RST_HOLD_TIME;
            r_stale_timeout <= rlm_pkg::RST_STALE_TIMEOUT;
            r_normal_decay  <= rlm_pkg::RST_NORMAL_DECAY;
            r_stale_decay   <= rlm_pkg::RST_STALE_DECAY;
            r_avg_shift     <= rlm_pkg::RST_AVERAGE_SHIFT;
        end else if (i_cfg_we) begin
            unique case (rlm_pkg::t_cfg_idx'(i_cfg_idx))
                rlm_pkg::CFG_SEGMENT_COUNT: r_seg_count     <= i_cfg_data[6:0];
                rlm_pkg::CFG_HOLD_TIME:     r_hold_time     <= i_cfg_data;
                rlm_pkg::CFG_STALE_TIMEOUT: r_stale_timeout <= i_cfg_data;
                rlm_pkg::CFG_NORMAL_DECAY:  r_normal_decay  <= i_cfg_data;
                rlm_pkg::CFG_STALE_DECAY:   r_stale_decay   <= i_cfg_data;
                rlm_pkg::CFG_AVERAGE_SHIFT: r_avg_shift     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg = '0;
        if (r_seg_count == 7'd0) begin
            o_cfg.seg_n = 7'd1;
        end else if (r_seg_count > SEG_CAP) begin
            o_cfg.seg_n = SEG_CAP;
        end else begin
            o_cfg.seg_n = r_seg_count;
        end
        o_cfg.hold_time     = r_hold_time;
        o_cfg.stale_timeout = r_stale_timeout;
        o_cfg.normal_decay  = r_normal_decay;
        o_cfg.stale_decay   = r_stale_decay;
        o_cfg.avg_shift     = r_avg_shift;
    end

endmodule

### design/rlm_update.sv
module rlm_update #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  rlm_pkg::t_cfg         i_cfg,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  logic                  i_present,
    input  logic signed [7:0]     i_dbm,
    input  logic [TIME_WIDTH-1:0] i_stamp,
    output rlm_pkg::t_level       o_level
);

    // tracker state
    logic signed [15:0]    r_avg;
    logic                  r_avg_valid;
    logic [TIME_WIDTH-1:0] r_last_seen;
    logic [TIME_WIDTH-1:0] r_last_stamp;
    logic [16:0]           r_peak;
    logic [TIME_WIDTH-1:0] r_hold_dl;
    logic [TIME_WIDTH-1:0] r_prev_time;
    rlm_pkg::t_level       r_level;

    logic signed [15:0]    n_avg;
    logic                  n_avg_valid;
    logic [TIME_WIDTH-1:0] n_last_seen;
    logic [TIME_WIDTH-1:0] n_hold_dl;
    rlm_pkg::t_level       n_level;

    logic [TIME_WIDTH-1:0] gap_full;
    logic [9:0]            gap;
    logic                  take;
    logic signed [15:0]    dbm_q88;
    logic signed [16:0]    diff;
    logic signed [16:0]    step;
    logic [16:0]           raw;
    logic                  capture;
    logic [16:0]           peak_cap;
    logic [TIME_WIDTH-1:0] age;
    logic [TIME_WIDTH-1:0] hd;
    logic                  stale;
    logic                  expired;
    logic [15:0]           rate;
    logic [25:0]           decay;
    logic [16:0]           decayed;
    logic [16:0]           smooth;

    always_comb begin
        gap_full = i_now - r_prev_time;
        gap      = (gap_full > TIME_WIDTH'(rlm_pkg::GAP_LIMIT)) ? rlm_pkg::GAP_DEFAULT
                                                                : gap_full[9:0];

        // repeated stamp means the sample was already taken
        take    = i_present && (i_stamp != r_last_stamp);
        dbm_q88 = {i_dbm, 8'b0};
        diff    = 17'(dbm_q88) - 17'(r_avg);
        step    = diff >>> i_cfg.avg_shift;

        n_avg = r_avg;
        if (take) begin
            n_avg = r_avg_valid ? 16'(17'(r_avg) + step) : dbm_q88;
        end
        n_avg_valid = r_avg_valid | take;
        n_last_seen = take ? i_stamp : r_last_seen;

        raw       = rlm_pkg::level_to_frac(dbm_q88);
        capture   = take && (raw >= r_peak);
        peak_cap  = capture ? raw : r_peak;
        n_hold_dl = capture ? (i_now + TIME_WIDTH'(i_cfg.hold_time)) : r_hold_dl;

        age     = i_now - n_last_seen;
        stale   = !n_avg_valid || (age > TIME_WIDTH'(i_cfg.stale_timeout));
        hd      = i_now - n_hold_dl;
        expired = (hd != '0) && !hd[TIME_WIDTH-1];

        rate  = stale ? i_cfg.stale_decay : i_cfg.normal_decay;
        decay = (stale || expired) ? (26'(rate) * 26'(gap)) : '0;
        decayed = (decay >= 26'(peak_cap)) ? '0 : (peak_cap - decay[16:0]);

        // peak is never below the smoothed level
        smooth = stale ? '0 : rlm_pkg::level_to_frac(n_avg);

        n_level.smooth = smooth;
        n_level.peak   = (smooth > decayed) ? smooth : decayed;
        n_level.stale  = stale;
        n_level.avg    = n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg        <= rlm_pkg::LEVEL_FLOOR_Q88;
            r_avg_valid  <= 1'b0;
            r_last_seen  <= '0;
            r_last_stamp <= '0;
            r_peak       <= '0;
            r_hold_dl    <= '0;
            r_prev_time  <= '0;
        end else if (i_go) begin
            r_avg        <= n_avg;
            r_avg_valid  <= n_avg_valid;
            r_last_seen  <= n_last_seen;
            r_last_stamp <= take ? i_stamp : r_last_stamp;
            r_peak       <= n_level.peak;
            r_hold_dl    <= n_hold_dl;
            r_prev_time  <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

### design/rlm_display.sv
module rlm_display (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [6:0]        i_seg_n,
    input  rlm_pkg::t_level   i_level,
    output rlm_pkg::t_result  o_result
);

    logic [6:0]       r_shown_lit;
    logic [6:0]       r_shown_pseg;
    logic             r_shown_stale;
    logic             r_first;
    rlm_pkg::t_result r_result;

    logic [23:0]      lit_sum;
    logic [23:0]      pseg_sum;
    logic [22:0]      pct_sum;
    logic [21:0]      pk_sum;
    logic [17:0]      lvl_sum;
    logic [6:0]       lit;
    logic [6:0]       pseg_raw;
    logic [6:0]       pseg;
    rlm_pkg::t_result n_result;

    always_comb begin
        lit_sum  = 24'(i_level.smooth) * 24'(i_seg_n) + 24'(rlm_pkg::SEG_ROUND);
        pseg_sum = 24'(i_level.peak) * 24'(i_seg_n) + 24'(rlm_pkg::SEG_ROUND);
        pct_sum  = 23'(i_level.smooth) * 23'(rlm_pkg::PCT_SCALE)
                 + 23'(rlm_pkg::HALF_FRAC);
        pk_sum   = 22'(i_level.peak) * 22'(rlm_pkg::DBM_SPAN) + 22'(rlm_pkg::HALF_FRAC);
        lvl_sum  = 18'(i_level.avg) + 18'(rlm_pkg::LEVEL_ROUND);

        lit      = lit_sum[22:16];
        pseg_raw = pseg_sum[22:16];
        pseg     = (pseg_raw >= i_seg_n) ? (i_seg_n - 7'd1) : pseg_raw;

        n_result.lit_segments  = lit;
        n_result.peak_segment  = pseg[5:0];
        n_result.peak_visible  = !i_level.stale && (i_level.peak > rlm_pkg::PEAK_VIS_MIN);
        n_result.is_stale      = i_level.stale;
        n_result.range_percent = pct_sum[22:16];
        n_result.level_dbm     = lvl_sum[15:8];
        n_result.peak_dbm      = $signed({2'b00, pk_sum[21:16]}) - rlm_pkg::DBM_FLOOR;
        n_result.redraw        = r_first || (lit != r_shown_lit) || (pseg != r_shown_pseg)
                               || (i_level.stale != r_shown_stale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown_lit   <= '0;
            r_shown_pseg  <= '0;
            r_shown_stale <= 1'b0;
            r_first       <= 1'b1;
        end else if (i_go) begin
            r_shown_lit   <= lit;
            r_shown_pseg  <= pseg;
            r_shown_stale <= i_level.stale;
            r_first       <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

### verif/rlm_meter_checker.sv
`timescale 1ns / 1ps

module rlm_meter_checker #(
    parameter int TIME_WIDTH   = 32,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rlm_frame_if                           frame_bus,
    rlm_result_if                          result_bus,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    typedef logic [TIME_WIDTH-1:0] t_ms;

    // register copies
    logic [6:0]  seg_reg;
    logic [15:0] hold_reg;
    logic [15:0] stale_reg;
    logic [15:0] norm_decay_reg;
    logic [15:0] stale_decay_reg;
    logic [2:0]  shift_reg;

    // tracker copy
    int          avg_q88;
    bit          avg_loaded;
    t_ms         seen_at;
    t_ms         stamp_used;
    t_ms         hold_until;
    t_ms         prev_frame_at;
    int unsigned peak_frac;
    int unsigned shown_lit;
    int unsigned shown_peak;
    bit          shown_stale;
    bit          first_pending;

    rlm_pkg::t_result displays_due[$];
    int               mismatch_total = 0;
    int               due_count = 0;

    assign o_mismatches  = mismatch_total;
    assign o_outstanding = due_count;

    // 60 dBm in q8.8 is 15360, so each q8.8 unit of offset is 64/15 q0.16 steps
    function automatic int unsigned frac_of_level(input int q88);
        int off;
        off = q88 + 25600;
        if (off <= 0) return 0;
        if (off >= 15360) return 65536;
        return (off * 64) / 15;
    endfunction

    function automatic int unsigned bar_position(input int unsigned frac, input int unsigned n);
        return (frac * n + 655) >> 16;
    endfunction

    function automatic void reset_meter();
        seg_reg         = 7'd38;
        hold_reg        = 16'd800;
        stale_reg       = 16'd5000;
        norm_decay_reg  = 16'd26;
        stale_decay_reg = 16'd98;
        shift_reg       = 3'd2;
        avg_q88         = -25600;
        avg_loaded      = 1'b0;
        seen_at         = '0;
        stamp_used      = '0;
        hold_until      = '0;
        prev_frame_at   = '0;
        peak_frac       = 0;
        shown_lit       = 0;
        shown_peak      = 0;
        shown_stale     = 1'b0;
        first_pending   = 1'b1;
    endfunction

    function automatic rlm_pkg::t_result advance_meter(input t_ms now, input bit present,
                                                       input logic signed [7:0] dbm,
                                                       input t_ms stamp);
        rlm_pkg::t_result r;
        int unsigned      n;
        int unsigned      smooth;
        int unsigned      lit;
        int unsigned      pseg;
        int               target;
        int               pdbm;
        t_ms              gap;
        t_ms              age;
        t_ms              since_hold;
        longint unsigned  decay;
        bit               stale;
        n = seg_reg;
        if (n < 1) n = 1;
        if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
        gap = now - prev_frame_at;
        if (gap > 1000) gap = 50;
        prev_frame_at = now;
        if (present && stamp != stamp_used) begin
            stamp_used = stamp;
            target     = int'(dbm) * 256;
            avg_q88    = avg_loaded ? avg_q88 + ((target - avg_q88) >>> shift_reg) : target;
            avg_loaded = 1'b1;
            seen_at    = stamp;
            if (frac_of_level(target) >= peak_frac) begin
                peak_frac  = frac_of_level(target);
                hold_until = now + t_ms'(hold_reg);
            end
        end
        age        = now - seen_at;
        stale      = !avg_loaded || age > stale_reg;
        since_hold = now - hold_until;
        decay      = 0;
        if (stale) begin
            decay = longint'(stale_decay_reg) * gap;
        end else if (since_hold != 0 && !since_hold[TIME_WIDTH-1]) begin
            decay = longint'(norm_decay_reg) * gap;
        end
        peak_frac = (decay >= peak_frac) ? 0 : peak_frac - 32'(decay);
        smooth    = stale ? 0 : frac_of_level(avg_q88);
        if (smooth > peak_frac) peak_frac = smooth;
        lit  = bar_position(smooth, n);
        pseg = bar_position(peak_frac, n);
        if (pseg >= n) pseg = n - 1;
        pdbm = int'((peak_frac * 60 + 32768) >> 16) - 100;
        r.lit_segments  = 7'(lit);
        r.peak_segment  = 6'(pseg);
        r.peak_visible  = !stale && peak_frac > 1310;
        r.is_stale      = stale;
        r.range_percent = 7'((smooth * 100 + 32768) >> 16);
        r.level_dbm     = 8'((avg_q88 + 128) >>> 8);
        r.peak_dbm      = 8'(pdbm);
        r.redraw        = first_pending || lit != shown_lit || pseg != shown_peak ||
                          stale != shown_stale;
        shown_lit     = lit;
        shown_peak    = pseg;
        shown_stale   = stale;
        first_pending = 1'b0;
        return r;
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_total++;
        end
    endfunction

    initial reset_meter();

    always @(posedge i_clk) begin
        rlm_pkg::t_result want;
        if (!i_rst_n) begin
            reset_meter();
            displays_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rlm_pkg::CFG_SEGMENT_COUNT: seg_reg         = i_cfg_data[6:0];
                    rlm_pkg::CFG_HOLD_TIME:     hold_reg        = i_cfg_data;
                    rlm_pkg::CFG_STALE_TIMEOUT: stale_reg       = i_cfg_data;
                    rlm_pkg::CFG_NORMAL_DECAY:  norm_decay_reg  = i_cfg_data;
                    rlm_pkg::CFG_STALE_DECAY:   stale_decay_reg = i_cfg_data;
                    rlm_pkg::CFG_AVERAGE_SHIFT: shift_reg       = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (result_bus.valid && result_bus.ready) begin
                if (displays_due.size() == 0) begin
                    $error("result beat with nothing pending");
                    mismatch_total++;
                end else begin
                    want = displays_due.pop_front();
                    compare_field("lit_segments", want.lit_segments, result_bus.lit_segments);
                    compare_field("peak_segment", want.peak_segment, result_bus.peak_segment);
                    compare_field("peak_visible", want.peak_visible, result_bus.peak_visible);
                    compare_field("is_stale", want.is_stale, result_bus.is_stale);
                    compare_field("range_percent", want.range_percent,
                                  result_bus.range_percent);
                    compare_field("level_dbm", $signed(want.level_dbm),
                                  $signed(result_bus.level_dbm));
                    compare_field("peak_dbm", $signed(want.peak_dbm),
                                  $signed(result_bus.peak_dbm));
                    compare_field("redraw", want.redraw, result_bus.redraw);
                end
            end
            if (frame_bus.valid && frame_bus.ready) begin
                displays_due.push_back(advance_meter(frame_bus.frame_time_ms,
                                                     frame_bus.sample_present,
                                                     frame_bus.sample_dbm,
                                                     frame_bus.sample_time_ms));
            end
        end
        due_count = displays_due.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int TIME_WIDTH   = 32;
    localparam int MAX_SEGMENTS = 64;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int BURST_CYCLES = 300;
    // indexes past the register file, writes there must change nothing
    localparam logic [rlm_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rlm_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic [TIME_WIDTH-1:0] t_ms;

    // raw register words, upper bits of the narrow ones left in on purpose
    typedef struct {
        logic [15:0] seg_word;
        logic [15:0] hold;
        logic [15:0] stale_to;
        logic [15:0] norm_decay;
        logic [15:0] stale_decay;
        logic [15:0] shift_word;
    } t_meter_setup;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rlm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rlm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rlm_frame_if #(.TIME_WIDTH(TIME_WIDTH)) frame_ch ();
    rlm_result_if                           result_ch ();

    int  mismatches;
    int  outstanding;
    int  cycle_count    = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    int  burst_len      = 0;   // nonzero asks the receiver for one long hold-off
    t_ms clock_ms       = '0;
    t_ms last_stamp     = '0;
    int  dropout_left   = 0;

    always #2 i_clk = ~i_clk;

    rssi_level_peak_hold_meter #(
        .TIME_WIDTH   (TIME_WIDTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (frame_ch),
        .o_result   (result_ch)
    );

    // watches both channels and the register port, predicts every display beat
    rlm_meter_checker #(
        .TIME_WIDTH   (TIME_WIDTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .frame_bus     (frame_ch),
        .result_bus    (result_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // watchdog, far beyond the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off counted here so the
    // three pipeline stages fill and the frame ready drops
    initial begin
        int burst_left;
        bit burst_taken;
        burst_left      = 0;
        burst_taken     = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!burst_taken && burst_len > 0) begin
                burst_left  = burst_len;
                burst_taken = 1'b1;
            end
            if (burst_left > 0) begin
                burst_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // one frame beat; valid stays up into the next call unless a gap is drawn
    task automatic offer_frame(input t_ms at_ms, input bit present,
                               input logic signed [7:0] dbm, input t_ms stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.frame_time_ms  <= at_ms;
        frame_ch.sample_present <= present;
        frame_ch.sample_dbm     <= dbm;
        frame_ch.sample_time_ms <= stamp;
        @(posedge i_clk);
        while (!frame_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register beat; the caller lowers the write enable after the last one
    task automatic put_reg(input logic [rlm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // registers only change with the pipeline drained
    task automatic load_setup(input t_meter_setup setup);
        frame_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        put_reg(rlm_pkg::CFG_SEGMENT_COUNT, setup.seg_word);
        put_reg(rlm_pkg::CFG_HOLD_TIME, setup.hold);
        put_reg(CFG_SPARE_LO, 16'($urandom));
        put_reg(rlm_pkg::CFG_STALE_TIMEOUT, setup.stale_to);
        put_reg(rlm_pkg::CFG_NORMAL_DECAY, setup.norm_decay);
        put_reg(rlm_pkg::CFG_STALE_DECAY, setup.stale_decay);
        put_reg(CFG_SPARE_HI, 16'($urandom));
        put_reg(rlm_pkg::CFG_AVERAGE_SHIFT, setup.shift_word);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly plausible frame streams: steady time steps, fresh samples a little
    // behind the frame time, dropouts long enough to go stale, and some noise
    task automatic run_phase(input t_meter_setup setup, input int src_pct,
                             input int sink_pct, input int beats, input int burst_at);
        bit                present;
        logic signed [7:0] dbm;
        t_ms               stamp;
        int                pick;
        load_setup(setup);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < beats; i++) begin
            if (i == burst_at) burst_len = BURST_CYCLES;
            pick = $urandom_range(99);
            if (pick < 70) begin
                clock_ms += $urandom_range(1, 60);
            end else if (pick < 80) begin
                clock_ms += $urandom_range(61, 1000);
            end else if (pick < 88) begin
                clock_ms += $urandom_range(1001, 200000);   // gap gets replaced
            end else if (pick < 94) begin
                clock_ms = $urandom;                        // jump, backwards too
            end
            // otherwise the frame time repeats
            if ($urandom_range(3) != 0) begin
                dbm = 8'(int'($urandom_range(90)) - 115);
            end else begin
                dbm = 8'($urandom);
            end
            stamp   = last_stamp;
            present = 1'b0;
            if (dropout_left > 0) begin
                dropout_left--;
                present = ($urandom_range(3) == 0);        // old sample offered again
            end else begin
                if ($urandom_range(99) < 3) dropout_left = $urandom_range(20, 150);
                pick = $urandom_range(99);
                if (pick < 8) begin
                    stamp = $urandom;                       // no sample, junk stamp
                end else if (pick < 15) begin
                    present = 1'b1;                         // repeated stamp
                end else begin
                    present = 1'b1;
                    if ($urandom_range(9) == 0) begin
                        stamp = $urandom;
                    end else begin
                        stamp = clock_ms - $urandom_range(20);
                    end
                end
            end
            if (present) last_stamp = stamp;
            offer_frame(clock_ms, present, dbm, stamp);
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = '0;
        i_cfg_data              = '0;
        frame_ch.valid          = 1'b0;
        frame_ch.frame_time_ms  = '0;
        frame_ch.sample_present = 1'b0;
        frame_ch.sample_dbm     = '0;
        frame_ch.sample_time_ms = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset register values
        offer_frame(32'd0, 1'b0, 8'sd0, 32'd0);         // first frame, nothing seen yet
        offer_frame(32'd50, 1'b1, -8'sd60, 32'd0);      // stamp equal to the reset stamp
        offer_frame(32'd100, 1'b1, -8'sd70, 32'd90);    // first sample loads the average
        offer_frame(32'd150, 1'b1, -8'sd40, 32'd90);    // repeated stamp ignored
        offer_frame(32'd200, 1'b1, -8'sd45, 32'd190);   // rising, new peak and hold
        offer_frame(32'd250, 1'b1, -8'sd90, 32'd240);   // falling, average floors down
        offer_frame(32'd300, 1'b1, 8'sd127, 32'd300);   // top of the byte, full scale
        offer_frame(32'd350, 1'b1, -8'sd128, 32'd340);  // bottom of the byte
        offer_frame(32'd350, 1'b0, -8'sd1, 32'd340);    // zero frame gap
        offer_frame(32'd1150, 1'b0, 8'sd0, 32'd0);      // hold over, normal decay
        offer_frame(32'd2200, 1'b0, 8'sd0, 32'd0);      // gap over a second
        offer_frame(32'd5340, 1'b0, 8'sd0, 32'd0);      // age right at the timeout
        offer_frame(32'd5341, 1'b0, 8'sd0, 32'd0);      // one past, stale decay
        offer_frame(32'hFFFF_FF00, 1'b1, -8'sd55, 32'hFFFF_FEF0);  // deadline wraps
        offer_frame(32'hFFFF_FFF0, 1'b1, -8'sd55, 32'hFFFF_FFF0);  // equal raw recaptures
        offer_frame(32'h0000_0010, 1'b0, 8'sd0, 32'd0);  // across the wrap, still held
        offer_frame(32'h0000_0400, 1'b0, 8'sd0, 32'd0);  // hold over after the wrap
        offer_frame(32'h7FFF_FFFF, 1'b1, 8'sd0, 32'hAAAA_AAAA);    // sample already old
        offer_frame(32'h8000_0000, 1'b1, -8'sd100, 32'h5555_5555);
        offer_frame(32'h8000_0010, 1'b1, -8'sd100, 32'h8000_0010); // bottom of the span
        offer_frame(32'h8000_0020, 1'b1, -8'sd40, 32'h8000_0020);  // top of the span
        offer_frame(32'h8000_0030, 1'b1, -8'sd99, 32'h8000_002F);
        clock_ms   = 32'h8000_0030;
        last_stamp = 32'h8000_002F;

        // one-segment bar, endless hold and timeout, no normal decay, unit weight;
        // no idling here, with the long result hold-off part way through
        run_phase('{16'hFF80, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFF8},
                  0, 0, 420, 120);
        // widest bar, no hold, zero timeout, steepest normal decay, weight 1/128
        run_phase('{16'h0040, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0007},
                  84, 0, 420, -1);
        // count above the maximum gets clamped
        run_phase('{16'h007F, 16'd300, 16'd400, 16'd100, 16'd500, 16'h0003},
                  0, 84, 420, -1);
        // count one past the maximum, mid values
        run_phase('{16'h0041, 16'd1200, 16'd1500, 16'd26, 16'd98, 16'h0001},
                  12, 12, 420, -1);

        // drain, then idle to catch anything stray
        frame_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
